### src/fbs_pkg.sv
// ----------------------------------------------------------------------------
// fbs_pkg
// Shared types, codes and helpers of the format driven byte swapper.
// ----------------------------------------------------------------------------
package fbs_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [1:0] REG_SLOTS_LOW  = 2'd0;
	localparam logic [1:0] REG_SLOTS_HIGH = 2'd1;
	localparam logic [1:0] REG_LENGTH     = 2'd2;
	localparam logic [1:0] REG_SWAP_EN    = 2'd3;

	localparam logic [3:0] CODE_PASS_MAX = 4'd9;
	localparam logic [3:0] CODE_BYTE     = 4'd10;
	localparam logic [3:0] CODE_SWAP2    = 4'd11;
	localparam logic [3:0] CODE_SWAP4    = 4'd12;

	// one accepted byte's worth of results
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            eos;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [3:0] code_len(input logic [3:0] code);
		logic [3:0] len;
		len = 4'd0;
		if (code <= CODE_PASS_MAX) begin
			len = code;
		end else begin
			unique case (code)
				CODE_BYTE:  len = 4'd1;
				CODE_SWAP2: len = 4'd2;
				CODE_SWAP4: len = 4'd4;
				default:    len = 4'd0;
			endcase
		end
		return len;
	endfunction

endpackage

### src/fbs_in_if.sv
// ----------------------------------------------------------------------------
// fbs_in_if
// Input byte channel: valid/ready with raw byte and end-of-stream mark.
// ----------------------------------------------------------------------------
interface fbs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

### src/fbs_out_if.sv
// ----------------------------------------------------------------------------
// fbs_out_if
// Output byte channel: valid/ready with converted byte and last marks.
// ----------------------------------------------------------------------------
interface fbs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       stream_last;

	modport source (output valid, output out_byte, output run_last, output stream_last,
		input ready);
	modport sink   (input valid, input out_byte, input run_last, input stream_last,
		output ready);
endinterface

### src/fbs_front.sv
// ----------------------------------------------------------------------------
// fbs_front
// Holds configuration and field state, classifies each input beat and
// builds the group of result bytes it causes.
// ----------------------------------------------------------------------------
module fbs_front #(
	parameter int FORMAT_SLOTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	fbs_in_if.sink             rx,
	input  fbs_pkg::q_stat_t   q_stat,
	output logic               push,
	output fbs_pkg::job_t      push_job
);

	localparam int SLOT_W = (FORMAT_SLOTS > 1) ? $clog2(FORMAT_SLOTS) : 1;
	localparam logic [5:0] LEN_MAX = 6'(FORMAT_SLOTS);

	logic [63:0]        slots_low_q;
	logic [63:0]        slots_high_q;
	logic [5:0]         length_q;
	logic               swap_en_q;

	logic [SLOT_W-1:0]  sp_q;
	logic [3:0]         fbl_q;
	logic [1:0]         hc_q;
	logic               swaps_q;
	logic [2:0][7:0]    held_q;

	logic [127:0]       slot_bits;
	logic [5:0]         len;
	logic [5:0]         start6;
	logic [FORMAT_SLOTS-1:0] nz;
	logic [FORMAT_SLOTS-1:0] hi;
	logic [SLOT_W-1:0]  hi_idx;
	logic [SLOT_W-1:0]  lo_idx;
	logic [SLOT_W-1:0]  found_idx;
	logic [3:0]         found_code;

	logic [SLOT_W-1:0]  sp_n;
	logic [3:0]         fbl_n;
	logic [1:0]         hc_n;
	logic               swaps_n;
	logic [2:0][7:0]    held_n;
	logic [3:0][7:0]    bytes;
	logic [2:0]         n;
	logic               have;
	logic [5:0]         nxt6;
	logic               accept;
	logic [7:0]         b;

	assign rx.ready  = !q_stat.full;
	assign accept    = rx.valid && rx.ready;
	assign b         = rx.data_byte;
	assign slot_bits = {slots_high_q, slots_low_q};

	always_comb begin
		if (length_q == 6'd0) begin
			len = 6'd1;
		end else if (length_q > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = length_q;
		end
	end

	assign start6 = (6'(sp_q) < len) ? 6'(sp_q) : 6'd0;

	// rotating priority search for the next slot with a nonzero length
	always_comb begin
		hi_idx = '0;
		lo_idx = '0;
		for (int i = 0; i < FORMAT_SLOTS; i++) begin
			nz[i] = (fbs_pkg::code_len(slot_bits[4*i +: 4]) != 4'd0) && (6'(i) < len);
			hi[i] = nz[i] && (6'(i) >= start6);
		end
		for (int i = FORMAT_SLOTS - 1; i >= 0; i--) begin
			if (hi[i]) hi_idx = SLOT_W'(i);
			if (nz[i]) lo_idx = SLOT_W'(i);
		end
	end

	assign found_idx  = (|hi) ? hi_idx : lo_idx;
	assign found_code = slot_bits[4*found_idx +: 4];

	always_comb begin
		sp_n    = sp_q;
		fbl_n   = fbl_q;
		hc_n    = hc_q;
		swaps_n = swaps_q;
		held_n  = held_q;
		bytes   = '0;
		n       = 3'd0;
		have    = 1'b1;
		nxt6    = 6'd0;

		if (!swap_en_q) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < hc_q && n < 3'd4) begin
					bytes[n[1:0]] = held_q[i];
					n = n + 3'd1;
				end
			end
			if (n < 3'd4) begin
				bytes[n[1:0]] = b;
				n = n + 3'd1;
			end
			hc_n  = 2'd0;
			fbl_n = 4'd0;
		end else begin
			if (fbl_q == 4'd0) begin
				have = |nz;
				if (have) begin
					sp_n    = found_idx;
					fbl_n   = fbs_pkg::code_len(found_code);
					swaps_n = (found_code == fbs_pkg::CODE_SWAP2) ||
						(found_code == fbs_pkg::CODE_SWAP4);
					hc_n    = 2'd0;
				end
			end
			if (!have || !swaps_n) begin
				bytes[0] = b;
				n = 3'd1;
				if (have) fbl_n = fbl_n - 4'd1;
			end else if (fbl_n > 4'd1) begin
				if (hc_n < 2'd3) begin
					held_n[hc_n] = b;
					hc_n = hc_n + 2'd1;
				end
				fbl_n = fbl_n - 4'd1;
			end else begin
				bytes[0] = b;
				n = 3'd1;
				for (int j = 2; j >= 0; j--) begin
					if (2'(j) < hc_n && n < 3'd4) begin
						bytes[n[1:0]] = held_q[j];
						n = n + 3'd1;
					end
				end
				hc_n  = 2'd0;
				fbl_n = 4'd0;
			end
			if (have && fbl_n == 4'd0) begin
				nxt6 = 6'(sp_n) + 6'd1;
				sp_n = (nxt6 >= len) ? '0 : nxt6[SLOT_W-1:0];
			end
		end

		if (rx.end_of_stream) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < hc_n && n < 3'd4) begin
					bytes[n[1:0]] = held_n[i];
					n = n + 3'd1;
				end
			end
			sp_n  = '0;
			fbl_n = 4'd0;
			hc_n  = 2'd0;
		end
	end

	assign push           = accept && (n != 3'd0);
	assign push_job.bytes = bytes;
	assign push_job.cnt   = n;
	assign push_job.eos   = rx.end_of_stream;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_low_q  <= '0;
			slots_high_q <= '0;
			length_q     <= 6'd1;
			swap_en_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fbs_pkg::REG_SLOTS_LOW:  slots_low_q  <= cfg_data;
				fbs_pkg::REG_SLOTS_HIGH: slots_high_q <= cfg_data;
				fbs_pkg::REG_LENGTH:     length_q     <= cfg_data[5:0];
				fbs_pkg::REG_SWAP_EN:    swap_en_q    <= cfg_data[0];
				default:                 ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			fbl_q   <= 4'd0;
			hc_q    <= 2'd0;
			swaps_q <= 1'b0;
		end else if (accept) begin
			sp_q    <= sp_n;
			fbl_q   <= fbl_n;
			hc_q    <= hc_n;
			swaps_q <= swaps_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) held_q <= held_n;
	end

endmodule

### src/fbs_queue.sv
// ----------------------------------------------------------------------------
// fbs_queue
// Short FIFO of result groups between the front and the back.
// ----------------------------------------------------------------------------
module fbs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fbs_pkg::job_t      push_job,
	input  logic               pop,
	output fbs_pkg::job_t      head,
	output fbs_pkg::q_stat_t   q_stat
);

	fbs_pkg::job_t                  store_q [fbs_pkg::QUEUE_DEPTH];
	logic [fbs_pkg::QPTR_W-1:0]     wr_q;
	logic [fbs_pkg::QPTR_W-1:0]     rd_q;
	logic [fbs_pkg::QCNT_W-1:0]     cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign q_stat.full  = (cnt_q == fbs_pkg::QCNT_W'(fbs_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = store_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) store_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### src/fbs_back.sv
// ----------------------------------------------------------------------------
// fbs_back
// Walks the head result group one byte per beat into the output register.
// ----------------------------------------------------------------------------
module fbs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  fbs_pkg::job_t      head,
	input  fbs_pkg::q_stat_t   q_stat,
	output logic               pop,
	fbs_out_if.source          tx
);

	logic       vld_q;
	logic [7:0] byte_q;
	logic       run_last_q;
	logic       stream_last_q;
	logic [1:0] pos_q;
	logic       load;
	logic       last;

	assign load = (!vld_q || tx.ready) && !q_stat.empty;
	assign last = (3'(pos_q) + 3'd1) >= head.cnt;
	assign pop  = load && last;

	assign tx.valid       = vld_q;
	assign tx.out_byte    = byte_q;
	assign tx.run_last    = run_last_q;
	assign tx.stream_last = stream_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			pos_q <= 2'd0;
		end else if (load) begin
			vld_q <= 1'b1;
			pos_q <= last ? 2'd0 : pos_q + 2'd1;
		end else if (tx.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q        <= head.bytes[pos_q];
			run_last_q    <= last;
			stream_last_q <= last && head.eos;
		end
	end

endmodule

### src/format_driven_byte_swapper_top.sv
// ----------------------------------------------------------------------------
// format_driven_byte_swapper_top
// Byte stream field swapper driven by a ring of format slots.
//
//   channel  dir  beat payload
//   feed     in   data_byte, end_of_stream
//   result   out  out_byte, run_last, stream_last
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// feed takes one byte per cycle while the result queue has room. result
// issues one byte per cycle while ready and a group waits; a byte's k
// results occupy the back end in turn. Results are registered in the queue,
// then at the output. The queue holds four groups, so a stalled result side
// throttles feed only once it is full. Reset is immediate, no clearing pass.
// ----------------------------------------------------------------------------
module format_driven_byte_swapper_top #(
	parameter int FORMAT_SLOTS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	fbs_in_if.sink       feed,
	fbs_out_if.source    result,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	fbs_pkg::job_t    push_job;
	fbs_pkg::job_t    head;
	fbs_pkg::q_stat_t q_stat;
	logic             push;
	logic             pop;

	fbs_front #(
		.FORMAT_SLOTS (FORMAT_SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (feed),
		.q_stat    (q_stat),
		.push      (push),
		.push_job  (push_job)
	);

	fbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	fbs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.tx     (result)
	);

endmodule

### src/fbs_checker.sv
// ----------------------------------------------------------------------------
// fbs_checker
// Port level checks on the byte swapper, bound to the top level.
// ----------------------------------------------------------------------------
module fbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_byte,
	input logic       res_run_last,
	input logic       res_stream_last
);

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_byte) &&
		$stable(res_run_last) && $stable(res_stream_last))
		else $error("result beat changed while stalled");

	// end of stream always closes a run
	a_stream_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stream_last |-> res_run_last)
		else $error("stream_last without run_last");

	// nothing offered while held in reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

endmodule

bind format_driven_byte_swapper_top fbs_checker u_fbs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.res_byte        (result.out_byte),
	.res_run_last    (result.run_last),
	.res_stream_last (result.stream_last)
);
